@@ hdl/dtdd_pkg.sv @@
// shared constants and types of the dihedral tuple duplicate detector
package dtdd_pkg;

  localparam int unsigned BUCKETS     = 1024;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned ARMS        = 6;
  localparam int unsigned ARM_W       = 32;
  localparam int unsigned TUPLE_W     = ARMS * ARM_W;
  localparam int unsigned OUT_W       = 8;
  localparam int unsigned BUCKET_W    = $clog2(BUCKETS);
  localparam int unsigned FILL_W      = $clog2(WAYS + 1);
  localparam int unsigned STORE_DEPTH = BUCKETS * WAYS;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [ARM_W-1:0] HASH_MASK  = ARM_W'(100003);
  localparam int unsigned      HASH_SHIFT = 8;

  typedef logic [ARMS-1:0][ARM_W-1:0] tuple_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic fill_rd;
    logic store_rd;
    logic way_inc;
    logic set_match;
    logic set_ovf;
    logic insert;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic twin;
    logic way_lt_fill;
    logic fill_full;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/dtdd_ram.sv @@
// generic single write port ram with registered read
module dtdd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/dtdd_ctrl.sv @@
// controller state machine: clearing pass, bucket probe and insert sequence
module dtdd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  dtdd_pkg::sts_t sts_i,
  output dtdd_pkg::cmd_t cmd_o
);
  import dtdd_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.twin ? ST_DONE : ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = ST_PROBE;
      end
      ST_PROBE: begin
        if (sts_i.way_lt_fill) begin
          cmd_o.store_rd = 1'b1;
          state_d        = ST_CHECK;
        end else if (sts_i.fill_full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = ST_DONE;
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_CHECK: begin
        if (sts_i.hit) begin
          cmd_o.set_match = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.way_inc = 1'b1;
          state_d       = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/dtdd_datapath.sv @@
// datapath: hash, fill counts, tuple store, dihedral compare, flags and result register
module dtdd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtdd_pkg::cmd_t                cmd_i,
  output dtdd_pkg::sts_t                sts_o,
  input  logic [dtdd_pkg::TUPLE_W-1:0]  s_tdata_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [dtdd_pkg::OUT_W-1:0]    m_tdata_o
);
  import dtdd_pkg::*;

  function automatic logic [BUCKET_W-1:0] bucket_of(input tuple_t t);
    logic [ARM_W-1:0] key;
    key = '0;
    for (int i = 0; i < ARMS; i++) begin
      key = key ^ (t[i] & HASH_MASK) ^ (t[i] >> HASH_SHIFT);
    end
    return key[BUCKET_W-1:0];
  endfunction

  tuple_t              tuple_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic [BUCKET_W-1:0] clr_cnt_q;
  logic [FILL_W-1:0]   way_q;
  logic                twin_q, ovf_q, match_q, stored_q;
  logic                out_valid_q;
  logic [3:0]          res_q;

  logic [FILL_W-1:0]   fill;
  logic                fill_we;
  logic [BUCKET_W-1:0] fill_waddr;
  logic [FILL_W-1:0]   fill_wdata;
  logic [STORE_AW-1:0] base_addr, rd_addr, wr_addr;
  logic [TUPLE_W-1:0]  store_rdata;
  tuple_t              slot;
  logic                hit;

  assign fill_we    = cmd_i.clear_step | cmd_i.insert;
  assign fill_waddr = cmd_i.clear_step ? clr_cnt_q : bucket_q;
  assign fill_wdata = cmd_i.clear_step ? '0 : fill + FILL_W'(1);

  dtdd_ram #(
    .Width (FILL_W),
    .Depth (BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (cmd_i.fill_rd),
    .raddr_i (bucket_q),
    .rdata_o (fill)
  );

  assign base_addr = STORE_AW'(bucket_q) * STORE_AW'(WAYS);
  assign rd_addr   = base_addr + STORE_AW'(way_q);
  assign wr_addr   = base_addr + STORE_AW'(fill);

  dtdd_ram #(
    .Width (TUPLE_W),
    .Depth (STORE_DEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.insert),
    .waddr_i (wr_addr),
    .wdata_i (tuple_q),
    .re_i    (cmd_i.store_rd),
    .raddr_i (rd_addr),
    .rdata_o (store_rdata)
  );

  assign slot = tuple_t'(store_rdata);

  logic [ARMS-1:0][ARMS-1:0] eq;
  logic [ARMS-1:0][ARMS-1:0] fwd_bits, rev_bits;
  logic [ARMS-1:0]           dir_hit;

  for (genvar i = 0; i < ARMS; i++) begin : g_eq_row
    for (genvar j = 0; j < ARMS; j++) begin : g_eq_col
      assign eq[i][j] = (slot[i] == tuple_q[j]);
    end
  end

  for (genvar k = 0; k < ARMS; k++) begin : g_rot
    for (genvar i = 0; i < ARMS; i++) begin : g_arm
      localparam int unsigned FwdIdx = (i + k) % ARMS;
      localparam int unsigned RevIdx = (ARMS - 1 - i + k) % ARMS;
      assign fwd_bits[k][i] = eq[i][FwdIdx];
      assign rev_bits[k][i] = eq[i][RevIdx];
    end
    assign dir_hit[k] = (&fwd_bits[k]) | (&rev_bits[k]);
  end

  assign hit = |dir_hit;

  assign sts_o.clear_last  = (clr_cnt_q == BUCKET_W'(BUCKETS - 1));
  assign sts_o.twin        = twin_q;
  assign sts_o.way_lt_fill = (way_q < fill);
  assign sts_o.fill_full   = (fill >= FILL_W'(WAYS));
  assign sts_o.hit         = hit;
  assign sts_o.out_free    = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tuple_q  <= tuple_t'(s_tdata_i);
      bucket_q <= bucket_of(tuple_t'(s_tdata_i));
    end
    if (cmd_i.load) begin
      match_q  <= 1'b0;
      stored_q <= 1'b0;
    end else begin
      if (cmd_i.set_match) begin
        match_q <= 1'b1;
      end
      if (cmd_i.insert) begin
        stored_q <= 1'b1;
      end
    end
    if (cmd_i.push) begin
      res_q <= {ovf_q, stored_q, twin_q, match_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      way_q       <= '0;
      twin_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + BUCKET_W'(1);
      end
      if (cmd_i.load) begin
        way_q <= '0;
      end else if (cmd_i.way_inc) begin
        way_q <= way_q + FILL_W'(1);
      end
      if (cmd_i.set_match) begin
        twin_q <= 1'b1;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(OUT_W - 4)'(0), res_q};

endmodule

@@ hdl/dihedral_tuple_duplicate_detector.sv @@
// top level of the dihedral tuple duplicate detector
//
//  channel   dir  width  contents
//  s_axis    in   192    arm_0 .. arm_5, 32 bits each
//  m_axis    out  8      item_matched, twin_seen, item_stored, bucket_overflow
//
// an item is accepted, the fill count of its bucket is read, then its stored tuples
// (up to WAYS) are read and compared one by one until one hits; with no hit it is
// inserted, or bucket_overflow set if the bucket is full. after a twin is seen no probe is made
// after reset the fill counts of all BUCKETS buckets are cleared one bucket a cycle,
// with s_axis_tready low
// a result waits in the output register while the next item is accepted and worked
module dihedral_tuple_duplicate_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dtdd_pkg::TUPLE_W-1:0] s_axis_tdata,  // arm_0 .. arm_5
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // item_matched, twin_seen, item_stored, bucket_overflow, zero pad
  output logic [dtdd_pkg::OUT_W-1:0]   m_axis_tdata
);
  import dtdd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dtdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtdd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

  a_twin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.twin |=> sts.twin)
    else $error("twin flag cleared");

  a_match_implies_twin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
    else $error("match reported without twin flag");

  a_match_not_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[2]))
    else $error("item both matched and stored");

  a_no_insert_after_twin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> !sts.twin)
    else $error("insert after twin");

endmodule
